// ----- rtl/core/cpcf_pkg.sv -----
// shared types, widths and register codes for the cylinder contact force core
package cpcf_pkg;

  // fixed point formats
  localparam int FRAC_BITS = 16;
  localparam int AXIS_FRAC = 14;
  localparam int AX_HALF   = 1 << (AXIS_FRAC - 1);
  localparam int F_HALF    = 1 << (FRAC_BITS - 1);

  // radial vector datapath widths
  localparam int V_W       = 33;
  localparam int P_W       = V_W + 16;
  localparam int DS_W      = P_W + 2;
  localparam int DOT_W     = DS_W - AXIS_FRAC;
  localparam int Q_W       = DOT_W + 16;
  localparam int R_W       = Q_W - AXIS_FRAC + 1;
  localparam int MAG_W     = R_W;
  localparam int MAG31_W   = 31;
  localparam int SHIFT_MAX = MAG_W - MAG31_W;
  localparam int SHIFT_W   = $clog2(SHIFT_MAX + 1);
  localparam int SQ_W      = 2 * MAG31_W;
  localparam int LEN_W     = 32 + SHIFT_MAX;

  // square root and divider chains
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int NUM_W      = 2 * MAG31_W;
  localparam int REM_W      = NUM_W + 1;
  localparam int DSH_W      = MAG31_W + DIV_STEPS - 1;

  // force scaling widths
  localparam int M1P_W  = MAG31_W + 32;
  localparam int M1_W   = 64 - FRAC_BITS;
  localparam int LO_W   = 24;
  localparam int HI_W   = M1_W - LO_W;
  localparam int PL_W   = LO_W + 32;
  localparam int PH_W   = HI_W + 32;
  localparam int PROD_W = M1_W + 33;
  localparam int RR_W   = PROD_W - FRAC_BITS;

  // configuration register indexes
  typedef enum logic [3:0] {
    CFG_RADIUS    = 4'd0,
    CFG_STIFFNESS = 4'd1,
    CFG_CENTER_X  = 4'd2,
    CFG_CENTER_Y  = 4'd3,
    CFG_CENTER_Z  = 4'd4,
    CFG_AXIS_X    = 4'd5,
    CFG_AXIS_Y    = 4'd6,
    CFG_AXIS_Z    = 4'd7
  } cpcf_cfg_t;

  // fields that ride along with a request
  typedef struct packed {
    logic [15:0] tag;
    logic        last;
    logic [31:0] scale;
  } cpcf_tok_t;

  typedef struct packed {
    cpcf_tok_t                      tok;
    logic [2:0][MAG31_W-1:0]        mag;
    logic [2:0]                     neg;
    logic [SHIFT_W-1:0]             shift;
  } cpcf_rad_side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
  } cpcf_sqrt_t;

  typedef struct packed {
    logic [2:0][REM_W-1:0]     rem;
    logic [2:0][DIV_STEPS-1:0] quo;
    logic [DSH_W-1:0]          dsh;
  } cpcf_div_t;

  typedef struct packed {
    cpcf_tok_t   tok;
    logic [2:0]  neg;
    logic        contact;
    logic        on_axis;
    logic [31:0] gap;
  } cpcf_div_side_t;

endpackage

// ----- rtl/core/cpcf_sqrt_cell.sv -----
// one step of the digit-by-digit integer square root
module cpcf_sqrt_cell
  import cpcf_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  cpcf_sqrt_t     sq_i,
  input  cpcf_rad_side_t side_i,
  output logic           vld_o,
  output cpcf_sqrt_t     sq_o,
  output cpcf_rad_side_t side_o
);

  logic           vld_r;
  cpcf_sqrt_t     sq_r;
  cpcf_sqrt_t     sq_nxt;
  cpcf_rad_side_t side_r;
  logic [64:0]    trial;
  logic           take;

  // trial subtract of root plus probe bit
  always_comb begin
    trial = {1'b0, sq_i.root} + {1'b0, sq_i.probe};
    take  = {1'b0, sq_i.rem} >= trial;
    sq_nxt.probe = sq_i.probe >> 2;
    if (take) begin
      sq_nxt.rem  = sq_i.rem - trial[63:0];
      sq_nxt.root = (sq_i.root >> 1) + sq_i.probe;
    end else begin
      sq_nxt.rem  = sq_i.rem;
      sq_nxt.root = sq_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r   <= sq_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign sq_o   = sq_r;
  assign side_o = side_r;

endmodule

// ----- rtl/core/cpcf_div_cell.sv -----
// one quotient bit of three restoring dividers sharing a divisor
module cpcf_div_cell
  import cpcf_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  cpcf_div_t      dv_i,
  input  cpcf_div_side_t side_i,
  output logic           vld_o,
  output cpcf_div_t      dv_o,
  output cpcf_div_side_t side_o
);

  logic           vld_r;
  cpcf_div_t      dv_r;
  cpcf_div_t      dv_nxt;
  cpcf_div_side_t side_r;
  logic [2:0]     take;

  // compare and subtract the aligned divisor in each lane
  always_comb begin
    dv_nxt.dsh = dv_i.dsh >> 1;
    for (int i = 0; i < 3; i++) begin
      take[i] = dv_i.rem[i] >= REM_W'(dv_i.dsh);
      dv_nxt.rem[i] = take[i] ? dv_i.rem[i] - REM_W'(dv_i.dsh) : dv_i.rem[i];
      dv_nxt.quo[i] = {dv_i.quo[i][DIV_STEPS-2:0], take[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r   <= dv_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign dv_o   = dv_r;
  assign side_o = side_r;

endmodule

// ----- rtl/core/cylinder_penalty_contact_force_core.sv -----
// top level: penalty contact force of a rigid cylinder, one node per request
//
// Takes one node request per clock unless the pipeline is held, and returns exactly one
// result per request, in order. The front stages form the radial vector and the sum of
// squares, a chain of 32 square root cells gives the radial length, the middle stages form
// gap and numerators, a chain of 32 divider cells forms the three force quotients, and the
// back stages scale, round and saturate into the output register. The whole pipeline
// advances together; when a result waits on out_ready the pipeline holds and in_ready is
// low. Configuration writes take effect at once and should only be made with the pipeline
// empty.
module cylinder_penalty_contact_force_core
  import cpcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_node_tag,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_force_scale,
  input  logic        in_last_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_tag_out,
  output logic [31:0] out_force_x,
  output logic [31:0] out_force_y,
  output logic [31:0] out_force_z,
  output logic [31:0] out_gap,
  output logic        out_in_contact,
  output logic        out_on_axis,
  output logic        out_last_out,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration registers
  logic [30:0]        radius_r;
  logic [31:0]        stiffness_r;
  logic signed [31:0] center_r [3];
  logic signed [15:0] axis_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= '0;
      stiffness_r <= '0;
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      axis_r[0]   <= '0;
      axis_r[1]   <= '0;
      axis_r[2]   <= 16'sd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS:    radius_r    <= cfg_wdata[30:0];
        CFG_STIFFNESS: stiffness_r <= cfg_wdata;
        CFG_CENTER_X:  center_r[0] <= cfg_wdata;
        CFG_CENTER_Y:  center_r[1] <= cfg_wdata;
        CFG_CENTER_Z:  center_r[2] <= cfg_wdata;
        CFG_AXIS_X:    axis_r[0]   <= cfg_wdata[15:0];
        CFG_AXIS_Y:    axis_r[1]   <= cfg_wdata[15:0];
        CFG_AXIS_Z:    axis_r[2]   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result is held
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic signed [31:0] pos_a [3];
  assign pos_a[0] = in_pos_x;
  assign pos_a[1] = in_pos_y;
  assign pos_a[2] = in_pos_z;

  // stage 1: offset from the centre point
  logic               s1_vld_r;
  cpcf_tok_t          s1_tok_r;
  cpcf_tok_t          s1_tok_nxt;
  logic signed [V_W-1:0] s1_v_r [3];
  logic signed [V_W-1:0] s1_v_nxt [3];

  always_comb begin
    s1_tok_nxt.tag   = in_node_tag;
    s1_tok_nxt.last  = in_last_node;
    s1_tok_nxt.scale = in_force_scale;
    for (int i = 0; i < 3; i++) begin
      s1_v_nxt[i] = V_W'(pos_a[i]) - V_W'(center_r[i]);
    end
  end

  // stage 2: offset times axis
  logic               s2_vld_r;
  cpcf_tok_t          s2_tok_r;
  logic signed [V_W-1:0] s2_v_r [3];
  logic signed [P_W-1:0] s2_p_r [3];
  logic signed [P_W-1:0] s2_p_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_p_nxt[i] = s1_v_r[i] * axis_r[i];
    end
  end

  // stage 3: dot product, rounded back to position format
  logic               s3_vld_r;
  cpcf_tok_t          s3_tok_r;
  logic signed [V_W-1:0]   s3_v_r [3];
  logic signed [DOT_W-1:0] s3_dot_r;
  logic signed [DOT_W-1:0] s3_dot_nxt;

  always_comb begin
    logic signed [DS_W-1:0] dsum;
    dsum = DS_W'(s2_p_r[0]) + DS_W'(s2_p_r[1]) + DS_W'(s2_p_r[2]) + DS_W'(AX_HALF);
    s3_dot_nxt = dsum[DS_W-1:AXIS_FRAC];
  end

  // stage 4: axial component times axis
  logic               s4_vld_r;
  cpcf_tok_t          s4_tok_r;
  logic signed [V_W-1:0] s4_v_r [3];
  logic signed [Q_W-1:0] s4_q_r [3];
  logic signed [Q_W-1:0] s4_q_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_q_nxt[i] = s3_dot_r * axis_r[i];
    end
  end

  // stage 5: radial vector as magnitude and sign
  logic               s5_vld_r;
  cpcf_tok_t          s5_tok_r;
  logic [MAG_W-1:0]   s5_mag_r [3];
  logic [MAG_W-1:0]   s5_mag_nxt [3];
  logic [2:0]         s5_neg_r;
  logic [2:0]         s5_neg_nxt;

  always_comb begin
    logic signed [Q_W-1:0] qs;
    logic signed [R_W-1:0] rv;
    for (int i = 0; i < 3; i++) begin
      qs = s4_q_r[i] + Q_W'(AX_HALF);
      rv = R_W'(s4_v_r[i]) - R_W'($signed(qs[Q_W-1:AXIS_FRAC]));
      s5_neg_nxt[i] = rv[R_W-1];
      s5_mag_nxt[i] = rv[R_W-1] ? MAG_W'(-rv) : MAG_W'(rv);
    end
  end

  // stage 6: prescale shift so every component fits 31 bits
  logic               s6_vld_r;
  cpcf_tok_t          s6_tok_r;
  logic [MAG_W-1:0]   s6_mag_r [3];
  logic [2:0]         s6_neg_r;
  logic [SHIFT_W-1:0] s6_shift_r;
  logic [SHIFT_W-1:0] s6_shift_nxt;

  always_comb begin
    logic [MAG_W-1:0] mx;
    mx = s5_mag_r[0];
    if (s5_mag_r[1] > mx) mx = s5_mag_r[1];
    if (s5_mag_r[2] > mx) mx = s5_mag_r[2];
    s6_shift_nxt = '0;
    for (int k = 1; k <= SHIFT_MAX; k++) begin
      if ((mx >> (MAG31_W - 1 + k)) != '0) s6_shift_nxt = SHIFT_W'(k);
    end
  end

  // stage 7: squares of the shifted components
  logic               s7_vld_r;
  cpcf_rad_side_t     s7_side_r;
  cpcf_rad_side_t     s7_side_nxt;
  logic [SQ_W-1:0]    s7_sq_r [3];
  logic [SQ_W-1:0]    s7_sq_nxt [3];

  always_comb begin
    logic [MAG31_W-1:0] t;
    s7_side_nxt.tok   = s6_tok_r;
    s7_side_nxt.neg   = s6_neg_r;
    s7_side_nxt.shift = s6_shift_r;
    for (int i = 0; i < 3; i++) begin
      t = MAG31_W'(s6_mag_r[i] >> s6_shift_r);
      s7_sq_nxt[i] = t * t;
      s7_side_nxt.mag[i] = s6_mag_r[i][MAG31_W-1:0];
    end
  end

  // stage 8: sum of squares feeds the root chain
  logic               s8_vld_r;
  cpcf_rad_side_t     s8_side_r;
  cpcf_sqrt_t         s8_sq_r;
  cpcf_sqrt_t         s8_sq_nxt;

  always_comb begin
    s8_sq_nxt.rem   = 64'(s7_sq_r[0]) + 64'(s7_sq_r[1]) + 64'(s7_sq_r[2]);
    s8_sq_nxt.root  = '0;
    s8_sq_nxt.probe = 64'd1 << 62;
  end

  // square root chain
  logic           sq_vld [SQRT_STEPS+1];
  cpcf_sqrt_t     sq_d [SQRT_STEPS+1];
  cpcf_rad_side_t sq_side [SQRT_STEPS+1];

  assign sq_vld[0]  = s8_vld_r;
  assign sq_d[0]    = s8_sq_r;
  assign sq_side[0] = s8_side_r;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    cpcf_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sq_vld[g]),
      .sq_i   (sq_d[g]),
      .side_i (sq_side[g]),
      .vld_o  (sq_vld[g+1]),
      .sq_o   (sq_d[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  // stage 9: length, gap, contact and penetration
  cpcf_rad_side_t     rt_side;
  logic               s9_vld_r;
  cpcf_div_side_t     s9_side_r;
  cpcf_div_side_t     s9_side_nxt;
  logic [MAG31_W-1:0] s9_mag_r [3];
  logic [MAG31_W-1:0] s9_pen_r;
  logic [MAG31_W-1:0] s9_pen_nxt;
  logic [MAG31_W-1:0] s9_dvs_r;
  logic [MAG31_W-1:0] s9_dvs_nxt;

  assign rt_side = sq_side[SQRT_STEPS];

  always_comb begin
    logic [LEN_W-1:0] len;
    logic signed [LEN_W:0] gw;
    logic contact;
    len     = LEN_W'(sq_d[SQRT_STEPS].root[31:0]) << rt_side.shift;
    contact = len < LEN_W'(radius_r);
    gw      = $signed({1'b0, len}) - $signed((LEN_W + 1)'(radius_r));
    s9_side_nxt.tok     = rt_side.tok;
    s9_side_nxt.neg     = rt_side.neg;
    s9_side_nxt.contact = contact;
    s9_side_nxt.on_axis = (len == '0);
    if (!contact && (gw[LEN_W:31] != '0)) begin
      s9_side_nxt.gap = 32'h7FFF_FFFF;
    end else begin
      s9_side_nxt.gap = gw[31:0];
    end
    s9_pen_nxt = contact ? radius_r - len[MAG31_W-1:0] : '0;
    s9_dvs_nxt = len[MAG31_W-1:0];
  end

  // stage 10: numerators of the three quotients
  logic               s10_vld_r;
  cpcf_div_side_t     s10_side_r;
  logic [NUM_W-1:0]   s10_num_r [3];
  logic [NUM_W-1:0]   s10_num_nxt [3];
  logic [MAG31_W-1:0] s10_dvs_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s10_num_nxt[i] = s9_mag_r[i] * s9_pen_r;
    end
  end

  // stage 11: add half the divisor for rounding, load the divider chain
  logic               s11_vld_r;
  cpcf_div_side_t     s11_side_r;
  cpcf_div_t          s11_dv_r;
  cpcf_div_t          s11_dv_nxt;

  always_comb begin
    s11_dv_nxt.dsh = {s10_dvs_r, (DIV_STEPS - 1)'(0)};
    for (int i = 0; i < 3; i++) begin
      s11_dv_nxt.rem[i] = REM_W'(s10_num_r[i]) + REM_W'(s10_dvs_r >> 1);
      s11_dv_nxt.quo[i] = '0;
    end
  end

  // divider chain
  logic           dv_vld [DIV_STEPS+1];
  cpcf_div_t      dv_d [DIV_STEPS+1];
  cpcf_div_side_t dv_side [DIV_STEPS+1];

  assign dv_vld[0]  = s11_vld_r;
  assign dv_d[0]    = s11_dv_r;
  assign dv_side[0] = s11_side_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    cpcf_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (dv_vld[g]),
      .dv_i   (dv_d[g]),
      .side_i (dv_side[g]),
      .vld_o  (dv_vld[g+1]),
      .dv_o   (dv_d[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  // stage 12: quotient times stiffness
  logic             s12_vld_r;
  cpcf_div_side_t   s12_side_r;
  logic [M1P_W-1:0] s12_m1p_r [3];
  logic [M1P_W-1:0] s12_m1p_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s12_m1p_nxt[i] = dv_d[DIV_STEPS].quo[i][MAG31_W-1:0] * stiffness_r;
    end
  end

  // stage 13: round back to position format
  logic             s13_vld_r;
  cpcf_div_side_t   s13_side_r;
  logic [M1_W-1:0]  s13_m1_r [3];
  logic [M1_W-1:0]  s13_m1_nxt [3];

  always_comb begin
    logic [63:0] rs;
    for (int i = 0; i < 3; i++) begin
      rs = 64'(s12_m1p_r[i]) + 64'(F_HALF);
      s13_m1_nxt[i] = rs[63:FRAC_BITS];
    end
  end

  // stage 14: partial products with the force scale
  logic             s14_vld_r;
  cpcf_div_side_t   s14_side_r;
  logic [PL_W-1:0]  s14_pl_r [3];
  logic [PL_W-1:0]  s14_pl_nxt [3];
  logic [PH_W-1:0]  s14_ph_r [3];
  logic [PH_W-1:0]  s14_ph_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s14_pl_nxt[i] = s13_m1_r[i][LO_W-1:0] * s13_side_r.tok.scale;
      s14_ph_nxt[i] = s13_m1_r[i][M1_W-1:LO_W] * s13_side_r.tok.scale;
    end
  end

  // output stage: combine, round, saturate and apply sign
  logic [31:0] out_force_r [3];
  logic [31:0] out_force_nxt [3];
  logic [15:0] out_tag_r;
  logic [31:0] out_gap_r;
  logic        out_contact_r;
  logic        out_axis_r;
  logic        out_last_r;

  always_comb begin
    logic [PROD_W-1:0] prod;
    logic [RR_W-1:0]   rr;
    logic [31:0]       m2;
    for (int i = 0; i < 3; i++) begin
      prod = (PROD_W'(s14_ph_r[i]) << LO_W) + PROD_W'(s14_pl_r[i]) + PROD_W'(F_HALF);
      rr   = prod[PROD_W-1:FRAC_BITS];
      m2   = (rr > RR_W'(64'h8000_0000)) ? 32'h8000_0000 : rr[31:0];
      if (!s14_side_r.contact || s14_side_r.on_axis) begin
        out_force_nxt[i] = '0;
      end else if (s14_side_r.neg[i]) begin
        out_force_nxt[i] = ~m2 + 32'd1;
      end else begin
        out_force_nxt[i] = m2[31] ? 32'h7FFF_FFFF : m2;
      end
    end
  end

  // valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      s5_vld_r    <= 1'b0;
      s6_vld_r    <= 1'b0;
      s7_vld_r    <= 1'b0;
      s8_vld_r    <= 1'b0;
      s9_vld_r    <= 1'b0;
      s10_vld_r   <= 1'b0;
      s11_vld_r   <= 1'b0;
      s12_vld_r   <= 1'b0;
      s13_vld_r   <= 1'b0;
      s14_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r    <= in_valid;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      s5_vld_r    <= s4_vld_r;
      s6_vld_r    <= s5_vld_r;
      s7_vld_r    <= s6_vld_r;
      s8_vld_r    <= s7_vld_r;
      s9_vld_r    <= sq_vld[SQRT_STEPS];
      s10_vld_r   <= s9_vld_r;
      s11_vld_r   <= s10_vld_r;
      s12_vld_r   <= dv_vld[DIV_STEPS];
      s13_vld_r   <= s12_vld_r;
      s14_vld_r   <= s13_vld_r;
      out_valid_r <= s14_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tok_r   <= s1_tok_nxt;
      s2_tok_r   <= s1_tok_r;
      s3_tok_r   <= s2_tok_r;
      s4_tok_r   <= s3_tok_r;
      s5_tok_r   <= s4_tok_r;
      s6_tok_r   <= s5_tok_r;
      s3_dot_r   <= s3_dot_nxt;
      s5_neg_r   <= s5_neg_nxt;
      s6_neg_r   <= s5_neg_r;
      s6_shift_r <= s6_shift_nxt;
      s7_side_r  <= s7_side_nxt;
      s8_side_r  <= s7_side_r;
      s8_sq_r    <= s8_sq_nxt;
      s9_side_r  <= s9_side_nxt;
      s9_pen_r   <= s9_pen_nxt;
      s9_dvs_r   <= s9_dvs_nxt;
      s10_side_r <= s9_side_r;
      s10_dvs_r  <= s9_dvs_r;
      s11_side_r <= s10_side_r;
      s11_dv_r   <= s11_dv_nxt;
      s12_side_r <= dv_side[DIV_STEPS];
      s13_side_r <= s12_side_r;
      s14_side_r <= s13_side_r;
      out_tag_r     <= s14_side_r.tok.tag;
      out_last_r    <= s14_side_r.tok.last;
      out_gap_r     <= s14_side_r.gap;
      out_contact_r <= s14_side_r.contact;
      out_axis_r    <= s14_side_r.on_axis;
      for (int i = 0; i < 3; i++) begin
        s1_v_r[i]      <= s1_v_nxt[i];
        s2_v_r[i]      <= s1_v_r[i];
        s2_p_r[i]      <= s2_p_nxt[i];
        s3_v_r[i]      <= s2_v_r[i];
        s4_v_r[i]      <= s3_v_r[i];
        s4_q_r[i]      <= s4_q_nxt[i];
        s5_mag_r[i]    <= s5_mag_nxt[i];
        s6_mag_r[i]    <= s5_mag_r[i];
        s7_sq_r[i]     <= s7_sq_nxt[i];
        s9_mag_r[i]    <= rt_side.mag[i];
        s10_num_r[i]   <= s10_num_nxt[i];
        s12_m1p_r[i]   <= s12_m1p_nxt[i];
        s13_m1_r[i]    <= s13_m1_nxt[i];
        s14_pl_r[i]    <= s14_pl_nxt[i];
        s14_ph_r[i]    <= s14_ph_nxt[i];
        out_force_r[i] <= out_force_nxt[i];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tag_out    = out_tag_r;
  assign out_force_x    = out_force_r[0];
  assign out_force_y    = out_force_r[1];
  assign out_force_z    = out_force_r[2];
  assign out_gap        = out_gap_r;
  assign out_in_contact = out_contact_r;
  assign out_on_axis    = out_axis_r;
  assign out_last_out   = out_last_r;

  // a node on the axis never pushes
  a_axis_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_on_axis) |->
      (out_force_x == '0 && out_force_y == '0 && out_force_z == '0))
    else $error("force on an on-axis node");

  // no contact means no force
  a_free_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_contact) |->
      (out_force_x == '0 && out_force_y == '0 && out_force_z == '0))
    else $error("force without contact");

  // contact flag agrees with a negative gap
  a_contact_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_contact == out_gap[31]))
    else $error("contact flag and gap sign disagree");

  // an empty output stage never blocks new requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule
